// File: rtl/core/qrs_pkg.sv
// shared widths, status codes and stage counts for the quadratic root solver
package qrs_pkg;

	localparam int COEF_W = 16;
	localparam int ROOT_W = 32;
	localparam int DISC_W = 35;
	localparam int RAD_W = 50;
	localparam int SQRT_W = 25;
	localparam int SREM_W = 28;
	localparam int NUM_W = 27;
	localparam int DMAG_W = 34;
	localparam int DREM_W = 17;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_ONE   = 2'd1,
		ST_TWO   = 2'd2,
		ST_AZERO = 2'd3
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [COEF_W-1:0]  a_mag;
		logic               a_neg;
	} side_t;

endpackage

// File: rtl/core/quadratic_root_solver.sv
// quadratic root solver top level: discriminant, pipelined square root and dividers
//
// input channel: coef_a, coef_b, coef_c (signed q8.8) with in_valid / in_stall
// output channel: root_status, root_first, root_second (signed q16.16) with
// out_valid / out_stall
// a transfer takes place on a rising edge with valid high and stall low
// one item may enter every cycle while in_stall is low; throughput is one
// result per cycle while out_stall is low; stages: products, discriminant, 25
// square root stages (one root bit each), one stage to form the numerators, 34
// divider stages (one quotient bit each) and the output register
// when the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated
// reset clears every valid bit; payload registers are not reset
// a zero a gives status 3, a negative discriminant status 0, both with
// zero roots; roots are rounded toward zero and saturated
module quadratic_root_solver (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [15:0]          coef_a,
	input  logic signed [15:0]          coef_b,
	input  logic signed [15:0]          coef_c,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  root_status,
	output logic signed [31:0]          root_first,
	output logic signed [31:0]          root_second
);
	import qrs_pkg::*;

	localparam int NSQ = SQRT_W;
	localparam int NDV = DMAG_W;

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	// products
	logic                      v_s1;
	logic signed [COEF_W-1:0]  a_s1, b_s1;
	logic signed [31:0]        bb_s1, ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_a;
			b_s1  <= coef_b;
			bb_s1 <= 32'(coef_b) * 32'(coef_b);
			ac_s1 <= 32'(coef_a) * 32'(coef_c);
		end
	end

	// discriminant and classification
	logic signed [DISC_W-1:0] dq_c;
	status_t                  st_c;
	assign dq_c = DISC_W'(bb_s1) - (DISC_W'(ac_s1) <<< 2);

	always_comb begin
		if (a_s1 == '0) st_c = ST_AZERO;
		else if (dq_c[DISC_W-1]) st_c = ST_NONE;
		else if (dq_c == '0) st_c = ST_ONE;
		else st_c = ST_TWO;
	end

	logic                      v_s2;
	logic signed [COEF_W-1:0]  b_s2;
	side_t                     side_s2;
	logic [RAD_W-1:0]          rad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s2           <= b_s1;
			side_s2.status <= st_c;
			side_s2.a_neg  <= a_s1[COEF_W-1];
			side_s2.a_mag  <= a_s1[COEF_W-1] ? COEF_W'(-a_s1) : COEF_W'(a_s1);
			rad_s2         <= dq_c[DISC_W-1] ? '0 : {dq_c[RAD_W-17:0], 16'd0};
		end
	end

	// square root, one result bit per stage
	logic                      v_sq    [0:NSQ];
	logic signed [COEF_W-1:0]  b_sq    [0:NSQ];
	side_t                     side_sq [0:NSQ];
	logic [RAD_W-1:0]          rad_sq  [0:NSQ];
	logic [SREM_W-1:0]         rem_sq  [0:NSQ];
	logic [SQRT_W-1:0]         root_sq [0:NSQ];

	assign v_sq[0]    = v_s2;
	assign b_sq[0]    = b_s2;
	assign side_sq[0] = side_s2;
	assign rad_sq[0]  = rad_s2;
	assign rem_sq[0]  = '0;
	assign root_sq[0] = '0;

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		logic [SREM_W-1:0] sh;
		logic [SREM_W-1:0] trial;
		assign sh    = {rem_sq[k][SREM_W-3:0], rad_sq[k][RAD_W-1 -: 2]};
		assign trial = SREM_W'({root_sq[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sq[k+1] <= 1'b0;
			else if (en) v_sq[k+1] <= v_sq[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				b_sq[k+1]    <= b_sq[k];
				side_sq[k+1] <= side_sq[k];
				rad_sq[k+1]  <= {rad_sq[k][RAD_W-3:0], 2'b00};
				if (sh >= trial) begin
					rem_sq[k+1]  <= sh - trial;
					root_sq[k+1] <= {root_sq[k][SQRT_W-2:0], 1'b1};
				end else begin
					rem_sq[k+1]  <= sh;
					root_sq[k+1] <= {root_sq[k][SQRT_W-2:0], 1'b0};
				end
			end
		end
	end

	// numerators, scaled by 128, as sign and magnitude
	logic signed [NUM_W-1:0] nb_c, n1_c, n2_c;
	logic signed [DMAG_W:0]  m1_c, m2_c;
	assign nb_c = -(NUM_W'(b_sq[NSQ]) <<< 8);
	assign n1_c = nb_c + NUM_W'(root_sq[NSQ]);
	assign n2_c = nb_c - NUM_W'(root_sq[NSQ]);
	assign m1_c = (DMAG_W+1)'(n1_c) <<< 7;
	assign m2_c = (DMAG_W+1)'(n2_c) <<< 7;

	logic               v_s3;
	side_t              side_s3;
	logic               neg1_s3, neg2_s3;
	logic [DMAG_W-1:0]  num1_s3, num2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_sq[NSQ];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_sq[NSQ];
			neg1_s3 <= m1_c[DMAG_W] ^ side_sq[NSQ].a_neg;
			neg2_s3 <= m2_c[DMAG_W] ^ side_sq[NSQ].a_neg;
			num1_s3 <= m1_c[DMAG_W] ? DMAG_W'(-m1_c) : DMAG_W'(m1_c);
			num2_s3 <= m2_c[DMAG_W] ? DMAG_W'(-m2_c) : DMAG_W'(m2_c);
		end
	end

	// two restoring dividers, one quotient bit per stage
	logic               v_dv    [0:NDV];
	side_t              side_dv [0:NDV];
	logic               neg1_dv [0:NDV];
	logic               neg2_dv [0:NDV];
	logic [DMAG_W-1:0]  q1_dv   [0:NDV];
	logic [DMAG_W-1:0]  q2_dv   [0:NDV];
	logic [DREM_W-1:0]  r1_dv   [0:NDV];
	logic [DREM_W-1:0]  r2_dv   [0:NDV];

	assign v_dv[0]    = v_s3;
	assign side_dv[0] = side_s3;
	assign neg1_dv[0] = neg1_s3;
	assign neg2_dv[0] = neg2_s3;
	assign q1_dv[0]   = num1_s3;
	assign q2_dv[0]   = num2_s3;
	assign r1_dv[0]   = '0;
	assign r2_dv[0]   = '0;

	for (genvar j = 0; j < NDV; j++) begin : g_div
		logic [DREM_W-1:0] d, sh1, sh2;
		assign d   = DREM_W'(side_dv[j].a_mag);
		assign sh1 = {r1_dv[j][DREM_W-2:0], q1_dv[j][DMAG_W-1]};
		assign sh2 = {r2_dv[j][DREM_W-2:0], q2_dv[j][DMAG_W-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_dv[j+1] <= 1'b0;
			else if (en) v_dv[j+1] <= v_dv[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_dv[j+1] <= side_dv[j];
				neg1_dv[j+1] <= neg1_dv[j];
				neg2_dv[j+1] <= neg2_dv[j];
				if (sh1 >= d) begin
					r1_dv[j+1] <= sh1 - d;
					q1_dv[j+1] <= {q1_dv[j][DMAG_W-2:0], 1'b1};
				end else begin
					r1_dv[j+1] <= sh1;
					q1_dv[j+1] <= {q1_dv[j][DMAG_W-2:0], 1'b0};
				end
				if (sh2 >= d) begin
					r2_dv[j+1] <= sh2 - d;
					q2_dv[j+1] <= {q2_dv[j][DMAG_W-2:0], 1'b1};
				end else begin
					r2_dv[j+1] <= sh2;
					q2_dv[j+1] <= {q2_dv[j][DMAG_W-2:0], 1'b0};
				end
			end
		end
	end

	// sign, saturation and masking
	function automatic logic signed [ROOT_W-1:0] sat_root(input logic neg,
			input logic [DMAG_W-1:0] mag);
		logic signed [DMAG_W:0] v;
		v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		if (v > (DMAG_W+1)'(64'sd2147483647)) return ROOT_W'(32'h7fff_ffff);
		else if (v < -(DMAG_W+1)'(64'sd2147483648)) return ROOT_W'(32'h8000_0000);
		else return v[ROOT_W-1:0];
	endfunction

	logic                      v_s4;
	status_t                   st_s4;
	logic signed [ROOT_W-1:0]  r1_s4, r2_s4;
	logic                      keep_c;
	assign keep_c = (side_dv[NDV].status == ST_ONE) || (side_dv[NDV].status == ST_TWO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_dv[NDV];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s4 <= side_dv[NDV].status;
			r1_s4 <= keep_c ? sat_root(neg1_dv[NDV], q1_dv[NDV]) : '0;
			r2_s4 <= keep_c ? sat_root(neg2_dv[NDV], q2_dv[NDV]) : '0;
		end
	end

	assign out_valid   = v_s4;
	assign root_status = st_s4;
	assign root_first  = r1_s4;
	assign root_second = r2_s4;

endmodule

// File: rtl/core/qrs_checker.sv
// port-level checker for the quadratic root solver and its bind
module qrs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         root_status,
	input logic signed [31:0] root_first,
	input logic signed [31:0] root_second
);
	import qrs_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(root_first) && $stable(root_second)
			&& $stable(root_status))
		else $error("stalled result changed");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output stall");

	a_zero_roots: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (root_status == ST_NONE || root_status == ST_AZERO)
			|-> root_first == '0 && root_second == '0)
		else $error("roots not zero without real solution");

	a_repeated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_status == ST_ONE |-> root_first == root_second)
		else $error("repeated root differs");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.root_status (root_status),
	.root_first  (root_first),
	.root_second (root_second)
);
